### rtl/disk_collision_time_defines.svh
// Assertion macros of the disk collision time RTL, used by the queue.
`ifndef DISK_COLLISION_TIME_DEFINES_SVH
`define DISK_COLLISION_TIME_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define DCT_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dct: implication check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define DCT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dct: next-cycle check failed");

`endif

### rtl/dct_pkg.sv
// Shared widths, latencies and types of the disk collision time block.
package dct_pkg;

    // Port fields
    localparam int IN_W  = 32;
    localparam int RAD_W = 31;
    localparam int OUT_W = 32;

    // Front datapath
    localparam int DIFF_W  = IN_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int RS_W    = RAD_W + 1;
    localparam int RSQ_W   = 2 * RS_W;
    localparam int A_W     = 66;
    localparam int B_W     = 67;
    localparam int C_W     = 67;
    localparam int MUL_W   = 66;
    localparam int MUL_LAT = 3;
    localparam int DISC_W  = 134;

    // Back datapath
    localparam int ROOT_W = DISC_W / 2;
    localparam int SR_W   = ROOT_W + 3;
    localparam int NUM_W  = 69;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DEN_W  = A_W;
    localparam int FRAC_W = 16;
    localparam int DVD_W  = MAG_W + FRAC_W;
    localparam int Q_W    = 34;
    localparam int HI_W   = DVD_W - Q_W;
    localparam int DIV_LAT = Q_W + 3;

    // Saturation limits of the Q16.16 result
    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One classified word handed from front to back
    typedef struct packed {
        logic                    ok;
        logic [DISC_W-1:0]       disc;
        logic signed [B_W-1:0]   nb;
        logic [DEN_W-1:0]        den;
    } t_job;

endpackage

### rtl/dct_mul.sv
// Three-stage unsigned multiplier built from a 3x3 grid of partial products.
module dct_mul #(
    parameter int W = dct_pkg::MUL_W
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    localparam int CW = (W + 2) / 3;
    localparam int XW = 3 * CW;
    localparam int PW = 2 * CW;
    localparam int SW = 6 * CW;

    logic [XW-1:0]  s_ax;
    logic [XW-1:0]  s_bx;
    logic [PW-1:0]  r_pp [0:2][0:2];
    logic [SW-1:0]  r_row [0:2];
    logic [SW-1:0]  s_sum;
    logic [2*W-1:0] r_p;

    assign s_ax = XW'(i_a);
    assign s_bx = XW'(i_b);

    // stage 1: chunk products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_pp[i][j] <= s_ax[i*CW +: CW] * s_bx[j*CW +: CW];
            end
        end
    end

    // stage 2: one row per chunk of a
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_row[i] <= SW'(r_pp[i][0]) + (SW'(r_pp[i][1]) << CW)
                      + (SW'(r_pp[i][2]) << (2 * CW));
        end
    end

    // stage 3: rows combined
    assign s_sum = r_row[0] + (r_row[1] << CW) + (r_row[2] << (2 * CW));

    always_ff @(posedge i_clk) begin
        r_p <= s_sum[2*W-1:0];
    end

    assign o_p = r_p;

endmodule

### rtl/dct_front.sv
// Front end: takes a disk pair, builds a, b, c and the discriminant, classifies.
module dct_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_x_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_y_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_x_vel,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_y_vel,
    input  logic [dct_pkg::RAD_W-1:0]       i_first_radius,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_x_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_y_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_x_vel,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_y_vel,
    input  logic [dct_pkg::RAD_W-1:0]       i_second_radius,
    output logic                           o_push,
    output dct_pkg::t_job                  o_job
);
    localparam int DIFF_W  = dct_pkg::DIFF_W;
    localparam int PROD_W  = dct_pkg::PROD_W;
    localparam int RS_W    = dct_pkg::RS_W;
    localparam int RSQ_W   = dct_pkg::RSQ_W;
    localparam int A_W     = dct_pkg::A_W;
    localparam int B_W     = dct_pkg::B_W;
    localparam int C_W     = dct_pkg::C_W;
    localparam int MUL_W   = dct_pkg::MUL_W;
    localparam int MUL_LAT = dct_pkg::MUL_LAT;
    localparam int DISC_W  = dct_pkg::DISC_W;
    localparam int DEN_W   = dct_pkg::DEN_W;

    // stage 1: differences and radius sum
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_dvx, r_dvy, r_dpx, r_dpy;
    logic [RS_W-1:0]          r_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvx <= {i_first_x_vel[dct_pkg::IN_W-1], i_first_x_vel}
               - {i_second_x_vel[dct_pkg::IN_W-1], i_second_x_vel};
        r_dvy <= {i_first_y_vel[dct_pkg::IN_W-1], i_first_y_vel}
               - {i_second_y_vel[dct_pkg::IN_W-1], i_second_y_vel};
        r_dpx <= {i_first_x_pos[dct_pkg::IN_W-1], i_first_x_pos}
               - {i_second_x_pos[dct_pkg::IN_W-1], i_second_x_pos};
        r_dpy <= {i_first_y_pos[dct_pkg::IN_W-1], i_first_y_pos}
               - {i_second_y_pos[dct_pkg::IN_W-1], i_second_y_pos};
        r_rs  <= {1'b0, i_first_radius} + {1'b0, i_second_radius};
    end

    // stage 2: the seven products
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_vxx, r_vyy, r_vpx, r_vpy, r_pxx, r_pyy;
    logic [RSQ_W-1:0]         r_rsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vxx <= r_dvx * r_dvx;
        r_vyy <= r_dvy * r_dvy;
        r_vpx <= r_dvx * r_dpx;
        r_vpy <= r_dvy * r_dpy;
        r_pxx <= r_dpx * r_dpx;
        r_pyy <= r_dpy * r_dpy;
        r_rsq <= r_rs * r_rs;
    end

    // stage 3: quadratic coefficients
    logic                  r_v3;
    logic [A_W-1:0]        r_a;
    logic signed [B_W-1:0] r_b;
    logic signed [C_W-1:0] r_c;
    logic signed [B_W-1:0] s_bsum;

    assign s_bsum = B_W'(r_vpx) + B_W'(r_vpy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= A_W'(r_vxx + r_vyy);
        r_b <= s_bsum <<< 1;
        r_c <= C_W'(r_pxx) + C_W'(r_pyy) - C_W'(r_rsq);
    end

    // stage 4: magnitudes for the wide multipliers
    logic                  r_v4;
    logic [MUL_W-1:0]      r_babs, r_cabs;
    logic                  r_cneg, r_anz;
    logic [A_W-1:0]        r_a4;
    logic signed [B_W-1:0] r_b4;
    logic [B_W-1:0]        s_babs;
    logic [C_W-1:0]        s_cabs;

    assign s_babs = r_b[B_W-1] ? B_W'(-r_b) : B_W'(r_b);
    assign s_cabs = r_c[C_W-1] ? C_W'(-r_c) : C_W'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_babs <= s_babs[MUL_W-1:0];
        r_cabs <= s_cabs[MUL_W-1:0];
        r_cneg <= r_c[C_W-1];
        r_anz  <= |r_a;
        r_a4   <= r_a;
        r_b4   <= r_b;
    end

    // b^2 and a|c|
    logic [2*MUL_W-1:0] s_bb, s_ac;

    dct_mul #(.W(MUL_W)) u_mul_bb (
        .i_clk (i_clk),
        .i_a   (r_babs),
        .i_b   (r_babs),
        .o_p   (s_bb)
    );

    dct_mul #(.W(MUL_W)) u_mul_ac (
        .i_clk (i_clk),
        .i_a   (r_a4),
        .i_b   (r_cabs),
        .o_p   (s_ac)
    );

    // side data follows the multipliers
    logic                  r_dv   [0:MUL_LAT-1];
    logic                  r_dcn  [0:MUL_LAT-1];
    logic                  r_danz [0:MUL_LAT-1];
    logic [A_W-1:0]        r_da   [0:MUL_LAT-1];
    logic signed [B_W-1:0] r_db   [0:MUL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MUL_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v4;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dcn[0]  <= r_cneg;
        r_danz[0] <= r_anz;
        r_da[0]   <= r_a4;
        r_db[0]   <= r_b4;
        for (int k = 1; k < MUL_LAT; k++) begin
            r_dcn[k]  <= r_dcn[k-1];
            r_danz[k] <= r_danz[k-1];
            r_da[k]   <= r_da[k-1];
            r_db[k]   <= r_db[k-1];
        end
    end

    // stage 8: discriminant and classification
    logic [DISC_W-1:0] s_bbx, s_ac4, s_disc;
    logic              r_push;
    dct_pkg::t_job     r_job;

    assign s_bbx  = DISC_W'(s_bb);
    assign s_ac4  = DISC_W'(s_ac) << 2;
    assign s_disc = r_dcn[MUL_LAT-1] ? s_bbx + s_ac4 : s_bbx - s_ac4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
        end else begin
            r_push <= r_dv[MUL_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_job.ok   <= r_danz[MUL_LAT-1] && !s_disc[DISC_W-1];
        r_job.disc <= s_disc;
        r_job.nb   <= -r_db[MUL_LAT-1];
        r_job.den  <= {r_da[MUL_LAT-1][DEN_W-2:0], 1'b0};
    end

    assign o_push = r_push;
    assign o_job  = r_job;

endmodule

### rtl/dct_queue.sv
// Short word queue between the front and back ends; drains one word per cycle.
`include "disk_collision_time_defines.svh"

module dct_queue #(
    parameter int DEPTH = dct_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dct_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output dct_pkg::t_job o_job
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dct_pkg::t_job    r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_full, r_valid;
    dct_pkg::t_job    r_out;
    logic             s_pop, s_wr;

    // the back end never stalls, so any stored word leaves at once
    assign s_pop   = (r_count != '0);
    assign s_wr    = i_push && !r_full;
    assign n_count = r_count + CNT_W'(s_wr) - CNT_W'(s_pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (s_wr) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (s_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= n_count;
            r_full  <= (n_count == CNT_W'(DEPTH));
            r_valid <= s_pop;
        end
    end

    // storage, registered read
    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr] <= i_job;
        end
        if (s_pop) begin
            r_out <= r_mem[r_rd];
        end
    end

    assign o_full  = r_full;
    assign o_valid = r_valid;
    assign o_job   = r_out;

    `DCT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !r_full)
    `DCT_ASSERT_IMP(a_read_had_word, i_clk, i_rst_n, r_valid, $past(r_count) != '0)
    `DCT_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, s_wr, r_count != '0)

endmodule

### rtl/dct_div.sv
// Pipelined signed divide by 2a with Q16.16 scaling, floor rounding and saturation.
module dct_div (
    input  logic                         i_clk,
    input  logic [dct_pkg::NUM_W-1:0]    i_num,
    input  logic [dct_pkg::DEN_W-1:0]    i_den,
    output logic [dct_pkg::OUT_W-1:0]    o_q
);
    localparam int NUM_W  = dct_pkg::NUM_W;
    localparam int MAG_W  = dct_pkg::MAG_W;
    localparam int DEN_W  = dct_pkg::DEN_W;
    localparam int FRAC_W = dct_pkg::FRAC_W;
    localparam int DVD_W  = dct_pkg::DVD_W;
    localparam int Q_W    = dct_pkg::Q_W;
    localparam int HI_W   = dct_pkg::HI_W;
    localparam int OUT_W  = dct_pkg::OUT_W;

    // stage A: sign and magnitude
    logic [NUM_W-1:0] s_abs;
    logic             r0_neg;
    logic [MAG_W-1:0] r0_mag;
    logic [DEN_W-1:0] r0_den;

    assign s_abs = i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;

    always_ff @(posedge i_clk) begin
        r0_neg <= i_num[NUM_W-1];
        r0_mag <= s_abs[MAG_W-1:0];
        r0_den <= i_den;
    end

    // stage B: high part of the scaled dividend, overflow check
    logic [DVD_W-1:0] s_dvd;
    logic [HI_W-1:0]  s_hi;
    logic             r1_neg, r1_big;
    logic [DEN_W-1:0] r1_rem, r1_den;
    logic [Q_W-1:0]   r1_low;

    assign s_dvd = {r0_mag, FRAC_W'(0)};
    assign s_hi  = s_dvd[DVD_W-1:Q_W];

    always_ff @(posedge i_clk) begin
        r1_neg <= r0_neg;
        r1_big <= (DEN_W'(s_hi) >= r0_den);
        r1_rem <= DEN_W'(s_hi);
        r1_low <= s_dvd[Q_W-1:0];
        r1_den <= r0_den;
    end

    // one quotient bit per stage
    logic [DEN_W-1:0] st_rem [0:Q_W-1];
    logic [DEN_W-1:0] st_den [0:Q_W-1];
    logic [Q_W-1:0]   st_low [0:Q_W-1];
    logic [Q_W-1:0]   st_q   [0:Q_W-1];
    logic             st_neg [0:Q_W-1];
    logic             st_big [0:Q_W-1];
    logic [DEN_W-1:0] n_rem  [0:Q_W-1];
    logic [Q_W-1:0]   n_q    [0:Q_W-1];
    logic [DEN_W-1:0] r_rem  [0:Q_W-1];
    logic [DEN_W-1:0] r_den  [0:Q_W-1];
    logic [Q_W-1:0]   r_low  [0:Q_W-1];
    logic [Q_W-1:0]   r_q    [0:Q_W-1];
    logic             r_neg  [0:Q_W-1];
    logic             r_big  [0:Q_W-1];

    always_comb begin
        logic [DEN_W:0] cur;
        st_rem[0] = r1_rem;
        st_den[0] = r1_den;
        st_low[0] = r1_low;
        st_q[0]   = '0;
        st_neg[0] = r1_neg;
        st_big[0] = r1_big;
        for (int k = 1; k < Q_W; k++) begin
            st_rem[k] = r_rem[k-1];
            st_den[k] = r_den[k-1];
            st_low[k] = r_low[k-1];
            st_q[k]   = r_q[k-1];
            st_neg[k] = r_neg[k-1];
            st_big[k] = r_big[k-1];
        end
        cur = '0;
        for (int k = 0; k < Q_W; k++) begin
            cur = {st_rem[k], st_low[k][Q_W-1]};
            if (cur >= {1'b0, st_den[k]}) begin
                n_rem[k] = DEN_W'(cur - {1'b0, st_den[k]});
                n_q[k]   = {st_q[k][Q_W-2:0], 1'b1};
            end else begin
                n_rem[k] = cur[DEN_W-1:0];
                n_q[k]   = {st_q[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_low[k] <= st_low[k] << 1;
            r_den[k] <= st_den[k];
            r_neg[k] <= st_neg[k];
            r_big[k] <= st_big[k];
        end
    end

    // floor rounding for negative values, then clamp
    logic [Q_W:0]     s_qc;
    logic [OUT_W-1:0] s_res, r_res;

    assign s_qc = (Q_W+1)'(r_q[Q_W-1]) + (Q_W+1)'(|r_rem[Q_W-1]);

    always_comb begin
        if (r_neg[Q_W-1]) begin
            if (r_big[Q_W-1] || (s_qc > (Q_W+1)'(dct_pkg::SAT_MIN))) begin
                s_res = dct_pkg::SAT_MIN;
            end else begin
                s_res = OUT_W'(-s_qc);
            end
        end else begin
            if (r_big[Q_W-1] || (r_q[Q_W-1] > Q_W'(dct_pkg::SAT_MAX))) begin
                s_res = dct_pkg::SAT_MAX;
            end else begin
                s_res = r_q[Q_W-1][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= s_res;
    end

    assign o_q = r_res;

endmodule

### rtl/dct_back.sv
// Back end: pipelined square root, both numerators, two dividers, result register.
module dct_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  dct_pkg::t_job                i_job,
    output logic                         o_strobe,
    output logic                         o_roots_valid,
    output logic [dct_pkg::OUT_W-1:0]    o_root_plus,
    output logic [dct_pkg::OUT_W-1:0]    o_root_minus
);
    localparam int DISC_W  = dct_pkg::DISC_W;
    localparam int ROOT_W  = dct_pkg::ROOT_W;
    localparam int SR_W    = dct_pkg::SR_W;
    localparam int B_W     = dct_pkg::B_W;
    localparam int DEN_W   = dct_pkg::DEN_W;
    localparam int NUM_W   = dct_pkg::NUM_W;
    localparam int OUT_W   = dct_pkg::OUT_W;
    localparam int DIV_LAT = dct_pkg::DIV_LAT;
    localparam int N       = ROOT_W;

    // square root: one result bit per stage
    logic                  st_v    [0:N-1];
    logic                  st_ok   [0:N-1];
    logic [SR_W-1:0]       st_rem  [0:N-1];
    logic [ROOT_W-1:0]     st_root [0:N-1];
    logic [DISC_W-1:0]     st_rad  [0:N-1];
    logic signed [B_W-1:0] st_nb   [0:N-1];
    logic [DEN_W-1:0]      st_den  [0:N-1];
    logic [SR_W-1:0]       n_rem   [0:N-1];
    logic [ROOT_W-1:0]     n_root  [0:N-1];

    logic                  r_v    [0:N-1];
    logic                  r_ok   [0:N-1];
    logic [SR_W-1:0]       r_rem  [0:N-1];
    logic [ROOT_W-1:0]     r_root [0:N-1];
    logic [DISC_W-1:0]     r_rad  [0:N-1];
    logic signed [B_W-1:0] r_nb   [0:N-1];
    logic [DEN_W-1:0]      r_den  [0:N-1];

    always_comb begin
        logic [SR_W-1:0] cur;
        logic [SR_W-1:0] trial;
        st_v[0]    = i_valid;
        st_ok[0]   = i_job.ok;
        st_rem[0]  = '0;
        st_root[0] = '0;
        st_rad[0]  = i_job.disc;
        st_nb[0]   = i_job.nb;
        st_den[0]  = i_job.den;
        for (int k = 1; k < N; k++) begin
            st_v[k]    = r_v[k-1];
            st_ok[k]   = r_ok[k-1];
            st_rem[k]  = r_rem[k-1];
            st_root[k] = r_root[k-1];
            st_rad[k]  = r_rad[k-1];
            st_nb[k]   = r_nb[k-1];
            st_den[k]  = r_den[k-1];
        end
        cur   = '0;
        trial = '0;
        for (int k = 0; k < N; k++) begin
            cur   = {st_rem[k][SR_W-3:0], st_rad[k][DISC_W-1 -: 2]};
            trial = SR_W'({st_root[k], 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {st_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {st_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= st_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            r_ok[k]   <= st_ok[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= st_rad[k] << 2;
            r_nb[k]   <= st_nb[k];
            r_den[k]  <= st_den[k];
        end
    end

    // numerators -b + s and -b - s
    logic [NUM_W-1:0] s_nbx, s_sx;
    logic             r_nv, r_nok;
    logic [NUM_W-1:0] r_np, r_nm;
    logic [DEN_W-1:0] r_nden;

    assign s_nbx = {{(NUM_W-B_W){r_nb[N-1][B_W-1]}}, r_nb[N-1]};
    assign s_sx  = NUM_W'(r_root[N-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else begin
            r_nv <= r_v[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_nok  <= r_ok[N-1];
        r_np   <= s_nbx + s_sx;
        r_nm   <= s_nbx - s_sx;
        r_nden <= r_den[N-1];
    end

    // the two divides
    logic [OUT_W-1:0] s_qp, s_qm;

    dct_div u_div_plus (
        .i_clk (i_clk),
        .i_num (r_np),
        .i_den (r_nden),
        .o_q   (s_qp)
    );

    dct_div u_div_minus (
        .i_clk (i_clk),
        .i_num (r_nm),
        .i_den (r_nden),
        .o_q   (s_qm)
    );

    // word tag follows the dividers
    logic r_vd  [0:DIV_LAT-1];
    logic r_okd [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else begin
            r_vd[0] <= r_nv;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_okd[0] <= r_nok;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_okd[k] <= r_okd[k-1];
        end
    end

    // result register; no real roots, or a zero a, gives zeros
    logic             r_strobe, r_rvalid;
    logic [OUT_W-1:0] r_rp, r_rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vd[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvalid <= r_okd[DIV_LAT-1];
        r_rp     <= r_okd[DIV_LAT-1] ? s_qp : '0;
        r_rm     <= r_okd[DIV_LAT-1] ? s_qm : '0;
    end

    assign o_strobe      = r_strobe;
    assign o_roots_valid = r_rvalid;
    assign o_root_plus   = r_rp;
    assign o_root_minus  = r_rm;

endmodule

### rtl/disk_collision_time.sv
// Throughput: one word per cycle while busy is low; the square root takes 67 stages
// and each divider 37 stages, one result bit per root or quotient stage, so every
// unit takes a new word each cycle.
// busy reports a full front/back queue; the back end drains it every cycle.
// Reset (i_rst_n low, synchronous) empties the queue and drops words in flight.
// The result strobe lasts one cycle and cannot be held off.
module disk_collision_time #(
    parameter int QUEUE_DEPTH = dct_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_x_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_y_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_x_vel,
    input  logic signed [dct_pkg::IN_W-1:0] i_first_y_vel,
    input  logic [dct_pkg::RAD_W-1:0]       i_first_radius,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_x_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_y_pos,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_x_vel,
    input  logic signed [dct_pkg::IN_W-1:0] i_second_y_vel,
    input  logic [dct_pkg::RAD_W-1:0]       i_second_radius,
    output logic                            o_strobe,
    output logic                            o_roots_valid,
    output logic signed [dct_pkg::OUT_W-1:0] o_root_plus,
    output logic signed [dct_pkg::OUT_W-1:0] o_root_minus
);
    logic          s_take, s_push, s_full, s_qvalid;
    dct_pkg::t_job s_fjob, s_qjob;
    logic [dct_pkg::OUT_W-1:0] s_rp, s_rm;

    assign s_take = start && !busy;
    assign busy   = s_full;

    dct_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_take),
        .i_first_x_pos   (i_first_x_pos),
        .i_first_y_pos   (i_first_y_pos),
        .i_first_x_vel   (i_first_x_vel),
        .i_first_y_vel   (i_first_y_vel),
        .i_first_radius  (i_first_radius),
        .i_second_x_pos  (i_second_x_pos),
        .i_second_y_pos  (i_second_y_pos),
        .i_second_x_vel  (i_second_x_vel),
        .i_second_y_vel  (i_second_y_vel),
        .i_second_radius (i_second_radius),
        .o_push          (s_push),
        .o_job           (s_fjob)
    );

    dct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_fjob),
        .o_full  (s_full),
        .o_valid (s_qvalid),
        .o_job   (s_qjob)
    );

    dct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_qvalid),
        .i_job         (s_qjob),
        .o_strobe      (o_strobe),
        .o_roots_valid (o_roots_valid),
        .o_root_plus   (s_rp),
        .o_root_minus  (s_rm)
    );

    assign o_root_plus  = s_rp;
    assign o_root_minus = s_rm;

endmodule
